// ----- design/adaptive_jitter_buffer_sizer_core_assert.svh -----
// Assertion macros shared by the checker of the jitter buffer sizer.
// Needs clk and rst_n in the scope of every use.
`ifndef ADAPTIVE_JITTER_BUFFER_SIZER_CORE_ASSERT_SVH
`define ADAPTIVE_JITTER_BUFFER_SIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define AJBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AJBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ajbs_pkg.sv -----
// Shared constants and types of the adaptive jitter buffer sizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ajbs_pkg;

  localparam int WinDepth = 500;
  localparam int WinAw    = 9;
  localparam int CntW     = 10;

  localparam logic [7:0]  PacketPeriodMs = 8'd20;
  localparam logic [31:0] StatusHoldMs   = 32'd1000;
  localparam logic [13:0] GoodOffset     = 14'd30;  // one period plus the good margin

  // divider and root widths
  localparam int DivDw = 97;
  localparam int DivVw = 18;
  localparam int SqIw  = 80;
  localparam int SqRw  = 40;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_GOOD   = 2'd2;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_BASE   = 2'd1;
  localparam logic [1:0] MODE_DECIDE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [2:0] REG_MIN_SIZE  = 3'd0;
  localparam logic [2:0] REG_MAX_SIZE  = 3'd1;
  localparam logic [2:0] REG_REDUCE_MS = 3'd2;
  localparam logic [2:0] REG_STEP      = 3'd3;
  localparam logic [2:0] REG_Z_FACTOR  = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DivDw-1:0] dividend;
    logic [DivVw-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDw-1:0] quot;
    logic [DivVw-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SqIw-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic            done;
    logic [SqRw-1:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

// ----- design/ajbs_win_ram.sv -----
// Jitter window storage: one write port, one registered read port.
// Depends on ajbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ajbs_win_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ajbs_pkg::WinAw-1:0] waddr,
  input  wire logic [31:0]               wdata,
  input  wire logic [ajbs_pkg::WinAw-1:0] raddr,
  output logic      [31:0]               rdata
);

  logic [31:0] mem [ajbs_pkg::WinDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/ajbs_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on ajbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ajbs_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ajbs_pkg::div_req_t req,
  output ajbs_pkg::div_rsp_t      rsp
);

  logic [6:0]                 cnt_r;
  logic                       done_r;
  logic [ajbs_pkg::DivDw-1:0] q_r;
  logic [ajbs_pkg::DivVw-1:0] rem_r, den_r;
  logic [ajbs_pkg::DivVw:0]   rem_sh;
  logic                       ge;
  logic [ajbs_pkg::DivVw:0]   diff;

  always_comb begin
    rem_sh = {rem_r, q_r[ajbs_pkg::DivDw-1]};
    ge     = rem_sh >= {1'b0, den_r};
    diff   = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= 7'(ajbs_pkg::DivDw);
        q_r   <= req.dividend;
        den_r <= req.divisor;
        rem_r <= '0;
      end else if (cnt_r != '0) begin
        q_r   <= {q_r[ajbs_pkg::DivDw-2:0], ge};
        rem_r <= ge ? diff[ajbs_pkg::DivVw-1:0] : rem_sh[ajbs_pkg::DivVw-1:0];
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ----- design/ajbs_isqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on ajbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ajbs_isqrt (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ajbs_pkg::sqrt_req_t req,
  output ajbs_pkg::sqrt_rsp_t      rsp
);

  logic [5:0]                  cnt_r;
  logic                        done_r;
  logic [ajbs_pkg::SqIw-1:0]   v_r;
  logic [ajbs_pkg::SqRw+1:0]   rem_r;
  logic [ajbs_pkg::SqRw-1:0]   root_r;
  logic [ajbs_pkg::SqRw+3:0]   rem_sh, trial, diff;
  logic                        ge;

  always_comb begin
    rem_sh = {rem_r, v_r[ajbs_pkg::SqIw-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r  <= 6'(ajbs_pkg::SqRw);
        v_r    <= req.radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (cnt_r != '0) begin
        v_r    <= {v_r[ajbs_pkg::SqIw-3:0], 2'b00};
        rem_r  <= ge ? diff[ajbs_pkg::SqRw+1:0] : rem_sh[ajbs_pkg::SqRw+1:0];
        root_r <= {root_r[ajbs_pkg::SqRw-2:0], ge};
        cnt_r  <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule
`default_nettype wire

// ----- design/adaptive_jitter_buffer_sizer_core.sv -----
// Adaptive jitter buffer sizer. A record transaction (tuser 0) turns a packet's timestamp and
// arrival time into a jitter value and, once a base is set, stores it in a 500-entry window; a base
// transaction (tuser 1) sets the reference times; a decide transaction (tuser 2) computes mean,
// standard deviation and maximum of the window and recommends a new buffer size; tuser 3 clears
// the state. Every transaction gives exactly one result. The block takes one transaction at a
// time. Decide reads the window one entry per cycle through the memory port, then runs a shared
// shift-add loop, two passes of the restoring divider and the bit-serial square root. The window
// memory needs no clearing pass.
// Depends on ajbs_pkg, ajbs_win_ram, ajbs_div, ajbs_isqrt.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_jitter_buffer_sizer_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [31:0] packet_timestamp, [63:32] arrival_time, [71:64] current_buffer_size,
  // [103:72] current_time
  input  wire logic [103:0] in_tdata,
  // [1:0] mode
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] jitter_ms, [39:32] next_buffer_size, [41:40] link state, [47:42] zero
  output logic [47:0]       out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ACC, S_MEAN_WAIT, S_MUL_N, S_MUL_S1, S_VAR_WAIT,
    S_SQRT_WAIT, S_TGT_MUL, S_TGT_SUM, S_DECIDE, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [7:0]  min_size_r, max_size_r, step_r;
  logic [31:0] reduce_ms_r;
  logic [15:0] z_r;

  // persistent state
  logic [ajbs_pkg::CntW-1:0]  count_r;
  logic [ajbs_pkg::WinAw-1:0] head_r;
  logic [31:0] base_pt_r, base_at_r, good_time_r, bad_time_r;
  logic [1:0]  link_r;

  // latched transaction
  logic [1:0]  mode_r;
  logic [31:0] ts_r, arr_r, now_r;
  logic [7:0]  cur_r;

  // statistics datapath
  logic [ajbs_pkg::WinAw-1:0] rd_addr_r;
  logic [ajbs_pkg::CntW-1:0]  rd_left_r;
  logic                       p1_r, p2_r, first_r;
  logic signed [31:0]         x_r, max_r;
  logic [63:0]                sq_r;
  logic signed [41:0]         s1_r;
  logic [70:0]                s2_r;
  logic [40:0]                m1_r;
  logic [40:0]                s1_mag;
  logic [40:0]                mb_r;
  logic [80:0]                mc_r, acc_r;
  logic [5:0]                 cnt_r;
  logic signed [40:0]         mean_r;
  logic [ajbs_pkg::SqRw-1:0]  dev_r;
  logic [55:0]                prod_r;
  logic signed [57:0]         target_r;

  // result
  logic [31:0] res_jit_r;
  logic [7:0]  res_next_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  logic [31:0] rd_data, mag, jit;
  logic        wr_en;
  logic        div_go_mean, div_go_var, sqrt_go;

  ajbs_pkg::div_req_t  div_req;
  ajbs_pkg::div_rsp_t  div_rsp;
  ajbs_pkg::sqrt_req_t sqrt_req;
  ajbs_pkg::sqrt_rsp_t sqrt_rsp;

  ajbs_win_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (head_r),
    .wdata (jit),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  ajbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ajbs_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // Jitter: arrival gap minus timestamp gap, all modulo 2^32.
  assign jit    = (arr_r - base_at_r) - (ts_r - base_pt_r);
  assign wr_en  = (state_r == S_EXEC) && (mode_r == ajbs_pkg::MODE_RECORD) && (base_pt_r != '0);
  assign mag    = rd_data[31] ? (~rd_data + 32'd1) : rd_data;
  assign s1_mag = s1_r[41] ? 41'(-s1_r) : s1_r[40:0];

  // Launch the divider after the last accumulate beat (mean) and after the last
  // shift-add beat (variance); launch the root when the variance quotient is in.
  assign div_go_mean = (state_r == S_ACC) && (rd_left_r == '0) && !p1_r && !p2_r;
  assign div_go_var  = (state_r == S_MUL_S1) && (cnt_r == '0);
  assign sqrt_go     = (state_r == S_VAR_WAIT) && div_rsp.done;

  always_comb begin
    div_req.start    = div_go_mean || div_go_var;
    div_req.dividend = div_go_mean ? {48'b0, s1_mag, 8'b0} : {acc_r[80:0], 16'b0};
    div_req.divisor  = div_go_mean ? {8'b0, count_r} : 18'(count_r * count_r);
    sqrt_req.start    = sqrt_go;
    sqrt_req.radicand = div_rsp.quot[ajbs_pkg::SqIw-1:0];
  end

  // Classification of the target against the present size.
  logic [12:0]        cur20;
  logic signed [13:0] thr;
  logic signed [57:0] bad_lim, good_lim;
  logic signed [31:0] thr32;
  logic               is_bad, is_good;
  logic [8:0]         grow_sum;
  logic [31:0]        since_bad, since_good;

  always_comb begin
    cur20      = 13'(cur_r * ajbs_pkg::PacketPeriodMs);
    thr        = $signed({1'b0, cur20} - ajbs_pkg::GoodOffset);
    bad_lim    = $signed({29'b0, cur20, 16'b0});
    good_lim   = $signed({{28{thr[13]}}, thr, 16'b0});
    thr32      = $signed({{18{thr[13]}}, thr});
    is_bad     = target_r >= bad_lim;
    is_good    = (target_r < good_lim) && (max_r < thr32);
    grow_sum   = {1'b0, cur_r} + {1'b0, step_r};
    since_bad  = now_r - bad_time_r;
    since_good = now_r - good_time_r;
  end

  logic [40:0] mean_mag;
  assign mean_mag = div_rsp.quot[40:0] + {40'b0, (div_rsp.rem != '0)};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_size_r  <= '0;
      max_size_r  <= '0;
      reduce_ms_r <= 32'd20000;
      step_r      <= 8'd2;
      z_r         <= 16'd640;
      count_r     <= '0;
      head_r      <= '0;
      base_pt_r   <= '0;
      base_at_r   <= '0;
      link_r      <= ajbs_pkg::ST_NORMAL;
      good_time_r <= '0;
      bad_time_r  <= '0;
      out_valid_r <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      rd_left_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          ajbs_pkg::REG_MIN_SIZE:  min_size_r  <= cfg_wdata[7:0];
          ajbs_pkg::REG_MAX_SIZE:  max_size_r  <= cfg_wdata[7:0];
          ajbs_pkg::REG_REDUCE_MS: reduce_ms_r <= cfg_wdata;
          ajbs_pkg::REG_STEP:      step_r      <= cfg_wdata[7:0];
          ajbs_pkg::REG_Z_FACTOR:  z_r         <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // drop the result once it is taken, unless the next one loads now
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r  <= in_tuser;
            ts_r    <= in_tdata[31:0];
            arr_r   <= in_tdata[63:32];
            cur_r   <= in_tdata[71:64];
            now_r   <= in_tdata[103:72];
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          unique case (mode_r)
            ajbs_pkg::MODE_RECORD: begin
              res_jit_r  <= (base_pt_r != '0) ? jit : '0;
              res_next_r <= '0;
              state_r    <= S_FIN;
              if (base_pt_r != '0) begin
                head_r    <= (head_r == 9'(ajbs_pkg::WinDepth - 1)) ? '0 : head_r + 9'd1;
                if (count_r < 10'(ajbs_pkg::WinDepth)) begin
                  count_r <= count_r + 10'd1;
                end
              end
            end
            ajbs_pkg::MODE_BASE: begin
              res_jit_r  <= '0;
              res_next_r <= '0;
              state_r    <= S_FIN;
              base_pt_r  <= ts_r;
              base_at_r  <= arr_r;
            end
            ajbs_pkg::MODE_DECIDE: begin
              res_jit_r  <= '0;
              res_next_r <= cur_r;
              s1_r       <= '0;
              s2_r       <= '0;
              max_r      <= '0;
              first_r    <= 1'b1;
              rd_addr_r  <= '0;
              rd_left_r  <= count_r;
              mean_r     <= '0;
              dev_r      <= '0;
              // an empty window skips straight to the target with zero statistics
              state_r    <= (count_r == '0) ? S_TGT_MUL : S_ACC;
            end
            default: begin
              res_jit_r   <= '0;
              res_next_r  <= '0;
              state_r     <= S_FIN;
              count_r     <= '0;
              head_r      <= '0;
              base_pt_r   <= '0;
              base_at_r   <= '0;
              link_r      <= ajbs_pkg::ST_NORMAL;
              good_time_r <= '0;
              bad_time_r  <= '0;
            end
          endcase
        end

        // Stream the window: issue, square, accumulate.
        S_ACC: begin
          p1_r <= (rd_left_r != '0);
          if (rd_left_r != '0) begin
            rd_addr_r <= rd_addr_r + 9'd1;
            rd_left_r <= rd_left_r - 10'd1;
          end
          p2_r <= p1_r;
          x_r  <= $signed(rd_data);
          sq_r <= mag * mag;
          if (p2_r) begin
            s1_r    <= s1_r + 42'(x_r);
            s2_r    <= s2_r + {7'b0, sq_r};
            first_r <= 1'b0;
            if (first_r || (x_r > max_r)) begin
              max_r <= x_r;
            end
          end
          if (div_go_mean) begin
            m1_r    <= s1_mag;
            state_r <= S_MEAN_WAIT;
          end
        end

        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean_r  <= s1_r[41] ? -$signed(mean_mag) : $signed(div_rsp.quot[40:0]);
            acc_r   <= '0;
            mc_r    <= {10'b0, s2_r};
            mb_r    <= {31'b0, count_r};
            cnt_r   <= 6'(ajbs_pkg::CntW);
            state_r <= S_MUL_N;
          end
        end

        // acc = n * S2, one multiplier bit per cycle
        S_MUL_N: begin
          if (cnt_r == '0) begin
            mc_r    <= {40'b0, m1_r};
            mb_r    <= m1_r;
            cnt_r   <= 6'd41;
            state_r <= S_MUL_S1;
          end else begin
            if (mb_r[0]) begin
              acc_r <= acc_r + mc_r;
            end
            mc_r  <= {mc_r[79:0], 1'b0};
            mb_r  <= {1'b0, mb_r[40:1]};
            cnt_r <= cnt_r - 6'd1;
          end
        end

        // acc -= S1 * S1, leaving n*S2 - S1^2
        S_MUL_S1: begin
          if (cnt_r == '0) begin
            state_r <= S_VAR_WAIT;
          end else begin
            if (mb_r[0]) begin
              acc_r <= acc_r - mc_r;
            end
            mc_r  <= {mc_r[79:0], 1'b0};
            mb_r  <= {1'b0, mb_r[40:1]};
            cnt_r <= cnt_r - 6'd1;
          end
        end

        S_VAR_WAIT: begin
          if (div_rsp.done) begin
            state_r <= S_SQRT_WAIT;
          end
        end

        S_SQRT_WAIT: begin
          if (sqrt_rsp.done) begin
            dev_r   <= sqrt_rsp.root;
            state_r <= S_TGT_MUL;
          end
        end

        S_TGT_MUL: begin
          prod_r  <= dev_r * z_r;
          state_r <= S_TGT_SUM;
        end

        S_TGT_SUM: begin
          target_r <= $signed({{9{mean_r[40]}}, mean_r, 8'b0}) + $signed({2'b0, prod_r});
          state_r  <= S_DECIDE;
        end

        S_DECIDE: begin
          state_r <= S_FIN;
          if (is_bad) begin
            link_r <= ajbs_pkg::ST_BAD;
            if ((bad_time_r == '0) || (since_bad >= ajbs_pkg::StatusHoldMs)) begin
              if (cur_r < max_size_r) begin
                res_next_r <= grow_sum[8] ? 8'hFF : grow_sum[7:0];
              end
              bad_time_r <= now_r;
            end
          end else if (is_good) begin
            if (link_r != ajbs_pkg::ST_GOOD) begin
              link_r      <= ajbs_pkg::ST_GOOD;
              good_time_r <= now_r;
            end else if (since_good >= reduce_ms_r) begin
              if (cur_r > min_size_r) begin
                res_next_r <= (cur_r > step_r) ? cur_r - step_r : 8'd0;
              end
              link_r <= ajbs_pkg::ST_NORMAL;
            end else begin
              link_r <= ajbs_pkg::ST_GOOD;
            end
          end else begin
            link_r <= ajbs_pkg::ST_NORMAL;
          end
        end

        // Hold until the output register is free.
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'b0, link_r, res_next_r, res_jit_r};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/ajbs_checker.sv -----
// Port-level checker of the jitter buffer sizer, bound to the top level.
// Depends on adaptive_jitter_buffer_sizer_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_jitter_buffer_sizer_core_assert.svh"
module ajbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  `AJBS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")
  `AJBS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready stayed high after accepting a transaction")
  `AJBS_ASSERT_NOW(a_status_code, out_tvalid, out_tdata[41:40] != 2'd3, "invalid network status")
  `AJBS_ASSERT_NOW(a_size_no_jitter, out_tvalid && (out_tdata[39:32] != 8'd0), out_tdata[31:0] == 32'd0, "size and jitter both nonzero")

endmodule

bind adaptive_jitter_buffer_sizer_core ajbs_checker u_ajbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
